// ===== rtl/core/asl_pkg.sv =====
package asl_pkg;

    localparam int ACC_W   = 58;
    localparam int NUM_W   = 37;
    localparam int SPD_W   = 16;
    localparam int STEPS   = 16;
    localparam int LATENCY = 38;

    localparam logic [2:0] REG_TOP_SPEED      = 3'd0;
    localparam logic [2:0] REG_BASE_SPEED     = 3'd1;
    localparam logic [2:0] REG_LAT_ACCEL_MAX  = 3'd2;
    localparam logic [2:0] REG_BRAKE_DECEL    = 3'd3;
    localparam logic [2:0] REG_REACTION_DELAY = 3'd4;
    localparam logic [2:0] REG_STOP_MARGIN    = 3'd5;
    localparam logic [2:0] REG_RAMP_DISTANCE  = 3'd6;
    localparam logic [2:0] REG_SPEED_STEP     = 3'd7;

    typedef enum logic [1:0] {
        RAMP_MAX,
        RAMP_MIN,
        RAMP_DIV
    } ramp_sel_t;

    typedef struct packed {
        logic [15:0] top_speed;
        logic [15:0] base_speed;
        logic [15:0] lat_accel_max;
        logic [15:0] brake_decel;
        logic [15:0] reaction_delay;
        logic [19:0] stop_margin;
        logic [19:0] ramp_distance;
        logic [15:0] speed_step;
    } cfg_t;

    typedef struct packed {
        logic             kzero;
        logic [23:0]      kmag;
        logic [ACC_W-1:0] ncurv;
        logic [ACC_W-1:0] fc;
        logic [ACC_W-1:0] incc;
        logic [15:0]      vc;
        logic             bok;
        logic [32:0]      bcoef;
        logic [ACC_W-1:0] nbrk;
        logic [ACC_W-1:0] fb;
        logic [ACC_W-1:0] incb;
        logic [15:0]      vb;
        ramp_sel_t        rsel;
        logic [NUM_W-1:0] rem;
        logic [15:0]      q;
        logic [15:0]      p;
    } srch_t;

endpackage

// ===== rtl/core/arc_speed_limiter.sv =====
// channel   direction  handshake                  payload
// input     in         start high, busy low       curvature, clear_length, goal_distance,
//                                                 previous_speed
// result    out        done, one cycle            speed_command
// config    in/out     apb psel/penable/pready    paddr, pwdata, prdata
//
// one transaction enters per cycle; busy is always low
// result is registered through the front stages, the tail stages and the 16-bit
// shift-and-compare search (two stages per bit) shared by sqrt, brake root and ramp divide
// reset clears valid bits and loads register defaults; no clearing pass
// the receiver cannot stall, so nothing holds the pipeline
module arc_speed_limiter
    import asl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] curvature,
    input  logic [20:0] clear_length,
    input  logic [20:0] goal_distance,
    input  logic [16:0] previous_speed,
    output logic        done,
    output logic [15:0] speed_command,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    logic  sv [STEPS+1];
    srch_t sd [STEPS+1];

    assign busy = 1'b0;

    asl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    asl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && !busy),
        .curvature      (curvature),
        .clear_length   (clear_length),
        .goal_distance  (goal_distance),
        .previous_speed (previous_speed),
        .cfg            (cfg),
        .out_valid      (sv[0]),
        .out_data       (sd[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        asl_step #(
            .BIT (STEPS - 1 - i)
        ) u_step (
            .clk           (clk),
            .rst_n         (rst_n),
            .in_valid      (sv[i]),
            .in_data       (sd[i]),
            .ramp_distance (cfg.ramp_distance),
            .out_valid     (sv[i+1]),
            .out_data      (sd[i+1])
        );
    end

    asl_tail u_tail (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (sv[STEPS]),
        .in_data       (sd[STEPS]),
        .cfg           (cfg),
        .done          (done),
        .speed_command (speed_command)
    );

endmodule

// ===== rtl/core/asl_regs.sv =====
module asl_regs
    import asl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_speed      <= 16'd1000;
            cfg_reg.base_speed     <= 16'd100;
            cfg_reg.lat_accel_max  <= 16'd2000;
            cfg_reg.brake_decel    <= 16'd1000;
            cfg_reg.reaction_delay <= 16'd100;
            cfg_reg.stop_margin    <= 20'd200;
            cfg_reg.ramp_distance  <= 20'd1000;
            cfg_reg.speed_step     <= 16'd50;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_TOP_SPEED:      cfg_reg.top_speed      <= pwdata[15:0];
                REG_BASE_SPEED:     cfg_reg.base_speed     <= pwdata[15:0];
                REG_LAT_ACCEL_MAX:  cfg_reg.lat_accel_max  <= pwdata[15:0];
                REG_BRAKE_DECEL:    cfg_reg.brake_decel    <= pwdata[15:0];
                REG_REACTION_DELAY: cfg_reg.reaction_delay <= pwdata[15:0];
                REG_STOP_MARGIN:    cfg_reg.stop_margin    <= pwdata[19:0];
                REG_RAMP_DISTANCE:  cfg_reg.ramp_distance  <= pwdata[19:0];
                REG_SPEED_STEP:     cfg_reg.speed_step     <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_TOP_SPEED:      prdata = {16'd0, cfg_reg.top_speed};
            REG_BASE_SPEED:     prdata = {16'd0, cfg_reg.base_speed};
            REG_LAT_ACCEL_MAX:  prdata = {16'd0, cfg_reg.lat_accel_max};
            REG_BRAKE_DECEL:    prdata = {16'd0, cfg_reg.brake_decel};
            REG_REACTION_DELAY: prdata = {16'd0, cfg_reg.reaction_delay};
            REG_STOP_MARGIN:    prdata = {12'd0, cfg_reg.stop_margin};
            REG_RAMP_DISTANCE:  prdata = {12'd0, cfg_reg.ramp_distance};
            REG_SPEED_STEP:     prdata = {16'd0, cfg_reg.speed_step};
        endcase
    end

endmodule

// ===== rtl/core/asl_front.sv =====
module asl_front
    import asl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [23:0] curvature,
    input  logic [20:0] clear_length,
    input  logic [20:0] goal_distance,
    input  logic [16:0] previous_speed,
    input  cfg_t        cfg,
    output logic        out_valid,
    output srch_t       out_data
);

    // stage 1
    logic        v1_reg;
    logic [23:0] kmag1_reg;
    logic        kzero1_reg;
    logic        flpos1_reg;
    logic [21:0] avail1_reg;
    logic [20:0] g1_reg;
    logic [15:0] p1_reg;
    logic [31:0] br1_reg;

    // stage 2
    logic             v2_reg;
    logic [23:0]      kmag2_reg;
    logic             kzero2_reg;
    logic [ACC_W-1:0] ncurv2_reg;
    logic             bok2_reg;
    logic [35:0]      bav2_reg;
    logic [35:0]      mg2_reg;
    logic [19:0]      rg2_reg;
    ramp_sel_t        rsel2_reg;
    logic [15:0]      p2_reg;
    logic [31:0]      br2_reg;

    // stage 3
    logic             v3_reg;
    logic [23:0]      kmag3_reg;
    logic             kzero3_reg;
    logic [ACC_W-1:0] ncurv3_reg;
    logic             bok3_reg;
    logic [46:0]      nbrk3_reg;
    logic [35:0]      mg3_reg;
    logic [35:0]      mr3_reg;
    ramp_sel_t        rsel3_reg;
    logic [15:0]      p3_reg;
    logic [32:0]      bcoef3_reg;

    // stage 4
    logic  v4_reg;
    srch_t s4_reg;

    logic [23:0] kmag_next;
    logic [21:0] avail_next;
    logic [25:0] lat1000;
    ramp_sel_t   rsel_next;

    assign kmag_next  = curvature[23] ? 24'(~curvature + 24'd1) : curvature;
    assign avail_next = {clear_length[20], clear_length} - {2'b00, cfg.stop_margin};
    assign lat1000    = 26'(cfg.lat_accel_max) * 26'd1000;

    always_comb
    begin
        priority if (cfg.ramp_distance == 20'd0
                     || $signed(g1_reg) >= $signed({1'b0, cfg.ramp_distance}))
            rsel_next = RAMP_MAX;
        else if (g1_reg[20] || g1_reg == 21'd0)
            rsel_next = RAMP_MIN;
        else
            rsel_next = RAMP_DIV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kmag1_reg  <= kmag_next;
        kzero1_reg <= (curvature == 24'd0);
        flpos1_reg <= !clear_length[20] && (clear_length != 21'd0);
        avail1_reg <= avail_next;
        g1_reg     <= goal_distance;
        p1_reg     <= previous_speed[16] ? 16'd0 : previous_speed[15:0];
        br1_reg    <= 32'(cfg.brake_decel) * 32'(cfg.reaction_delay);

        kmag2_reg  <= kmag1_reg;
        kzero2_reg <= kzero1_reg;
        ncurv2_reg <= ACC_W'({lat1000, 16'd0});
        bok2_reg   <= flpos1_reg && !avail1_reg[21] && (avail1_reg != 22'd0);
        bav2_reg   <= 36'(cfg.brake_decel) * 36'(avail1_reg[19:0]);
        mg2_reg    <= 36'(cfg.top_speed) * 36'(g1_reg[19:0]);
        rg2_reg    <= cfg.ramp_distance - g1_reg[19:0];
        rsel2_reg  <= rsel_next;
        p2_reg     <= p1_reg;
        br2_reg    <= br1_reg;

        kmag3_reg  <= kmag2_reg;
        kzero3_reg <= kzero2_reg;
        ncurv3_reg <= ncurv2_reg;
        bok3_reg   <= bok2_reg;
        nbrk3_reg  <= 47'(bav2_reg) * 47'd2000;
        mg3_reg    <= mg2_reg;
        mr3_reg    <= 36'(cfg.base_speed) * 36'(rg2_reg);
        rsel3_reg  <= rsel2_reg;
        p3_reg     <= p2_reg;
        bcoef3_reg <= {br2_reg, 1'b0};

        s4_reg.kzero <= kzero3_reg;
        s4_reg.kmag  <= kmag3_reg;
        s4_reg.ncurv <= ncurv3_reg;
        s4_reg.fc    <= '0;
        s4_reg.incc  <= '0;
        s4_reg.vc    <= '0;
        s4_reg.bok   <= bok3_reg;
        s4_reg.bcoef <= bcoef3_reg;
        s4_reg.nbrk  <= ACC_W'(nbrk3_reg);
        s4_reg.fb    <= '0;
        s4_reg.incb  <= '0;
        s4_reg.vb    <= '0;
        s4_reg.rsel  <= rsel3_reg;
        s4_reg.rem   <= NUM_W'(mg3_reg) + NUM_W'(mr3_reg);
        s4_reg.q     <= '0;
        s4_reg.p     <= p3_reg;
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

// ===== rtl/core/asl_step.sv =====
module asl_step
    import asl_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  srch_t       in_data,
    input  logic [19:0] ramp_distance,
    output logic        out_valid,
    output srch_t       out_data
);

    localparam logic [15:0] BIT_V = 16'(1) << BIT;

    logic             a_valid_reg;
    srch_t            a_reg;
    logic             b_valid_reg;
    srch_t            b_reg;
    logic [16:0]      m_c;
    logic [16:0]      m_b;
    logic [ACC_W-1:0] incc_next;
    logic [ACC_W-1:0] incb_next;
    logic [ACC_W-1:0] sum_c;
    logic [ACC_W-1:0] sum_b;
    logic [NUM_W-1:0] dsh;
    srch_t            a_next;
    srch_t            b_next;

    // candidate term (2v + bit) * bit for the incremental square
    assign m_c       = {in_data.vc, 1'b0} | {1'b0, BIT_V};
    assign m_b       = {in_data.vb, 1'b0} | {1'b0, BIT_V};
    assign incc_next = ACC_W'(41'(m_c) * 41'(in_data.kmag)) << BIT;
    assign incb_next = ACC_W'(34'(m_b) * 34'd1000 + 34'(in_data.bcoef)) << BIT;

    assign sum_c = a_reg.fc + a_reg.incc;
    assign sum_b = a_reg.fb + a_reg.incb;
    assign dsh   = NUM_W'(ramp_distance) << BIT;

    always_comb
    begin
        a_next      = in_data;
        a_next.incc = incc_next;
        a_next.incb = incb_next;
    end

    always_comb
    begin
        b_next = a_reg;
        if (sum_c <= a_reg.ncurv)
        begin
            b_next.fc = sum_c;
            b_next.vc = a_reg.vc | BIT_V;
        end
        if (sum_b <= a_reg.nbrk)
        begin
            b_next.fb = sum_b;
            b_next.vb = a_reg.vb | BIT_V;
        end
        if (a_reg.rem >= dsh)
        begin
            b_next.rem = a_reg.rem - dsh;
            b_next.q   = a_reg.q | BIT_V;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

// ===== rtl/core/asl_tail.sv =====
module asl_tail
    import asl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  srch_t       in_data,
    input  cfg_t        cfg,
    output logic        done,
    output logic [15:0] speed_command
);

    logic        t1_valid_reg;
    logic [15:0] lim_reg;
    logic [15:0] p_reg;
    logic        done_reg;
    logic [15:0] cmd_reg;

    logic [15:0] curve_lim;
    logic [15:0] brake_lim;
    logic [15:0] ramp_lim;
    logic [15:0] lim_next;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [17:0] x;

    always_comb
    begin
        curve_lim = in_data.kzero ? cfg.top_speed : in_data.vc;
        brake_lim = in_data.bok ? in_data.vb : 16'd0;
        unique case (in_data.rsel)
            RAMP_MAX: ramp_lim = cfg.top_speed;
            RAMP_MIN: ramp_lim = cfg.base_speed;
            RAMP_DIV: ramp_lim = in_data.q;
            default:  ramp_lim = cfg.top_speed;
        endcase
        lim_next = cfg.top_speed;
        if (curve_lim < lim_next)
            lim_next = curve_lim;
        if (brake_lim < lim_next)
            lim_next = brake_lim;
        if (ramp_lim < lim_next)
            lim_next = ramp_lim;
    end

    always_comb
    begin
        lo = {2'b00, p_reg} - {2'b00, cfg.speed_step};
        hi = {2'b00, p_reg} + {2'b00, cfg.speed_step};
        x  = {2'b00, lim_reg};
        if ($signed(x) < $signed(lo))
            x = lo;
        if ($signed(x) > $signed(hi))
            x = hi;
        if (x[17])
            x = 18'd0;
        if (x > {2'b00, cfg.top_speed})
            x = {2'b00, cfg.top_speed};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= in_valid;
            done_reg     <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        p_reg   <= in_data.p;
        cmd_reg <= x[15:0];
    end

    assign done          = done_reg;
    assign speed_command = cmd_reg;

endmodule

// ===== rtl/core/asl_checker.sv =====
module asl_checker
    import asl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    a_no_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_pready : assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_accept_done : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction gave no result strobe");

    a_done_source : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without accepted transaction");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result strobe right after reset");

endmodule

bind arc_speed_limiter asl_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);

// ===== bench/arc_speed_limiter_tb.sv =====
module arc_speed_limiter_tb;
    import asl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [23:0] curvature;
    logic [20:0] clear_length;
    logic [20:0] goal_distance;
    logic [16:0] previous_speed;
    logic        done;
    logic [15:0] speed_command;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    longint unsigned lim_max;
    longint unsigned lim_min;
    longint unsigned lim_lat;
    longint unsigned lim_brake;
    longint unsigned lim_delay;
    longint unsigned lim_margin;
    longint unsigned lim_ramp;
    longint unsigned lim_step;

    int n_items;
    int n_phases;
    bit quiet;

    arc_speed_limiter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .curvature(curvature), .clear_length(clear_length),
        .goal_distance(goal_distance), .previous_speed(previous_speed),
        .done(done), .speed_command(speed_command),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] predict_speed(logic [23:0] k, logic [20:0] fl_in,
                                                  logic [20:0] g_in, logic [16:0] p_in);
        longint kv;
        longint fl;
        longint g;
        longint p;
        longint lim;
        longint t;
        longint avail;
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned v;
        kv = longint'($signed(k));
        fl = longint'($signed(fl_in));
        g = longint'($signed(g_in));
        p = longint'($signed(p_in));
        lim = longint'(lim_max);
        if (kv != 0)
        begin
            mag = (kv < 0) ? -kv : kv;
            v = floor_sqrt((lim_lat * 64'd65536000) / mag);
            t = (v < lim_max) ? longint'(v) : longint'(lim_max);
            if (t < lim) lim = t;
        end
        avail = fl - longint'(lim_margin);
        if (fl <= 0 || avail <= 0)
            t = 0;
        else
        begin
            rhs = 64'd2000 * lim_brake * longint'(avail);
            lo = 0;
            hi = lim_max;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (64'd1000 * mid * mid + 64'd2 * lim_brake * lim_delay * mid <= rhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            t = longint'(lo);
        end
        if (t < lim) lim = t;
        if (lim_ramp == 0 || g >= longint'(lim_ramp))
            t = longint'(lim_max);
        else if (g <= 0)
            t = longint'(lim_min);
        else
            t = longint'((lim_max * g + lim_min * (lim_ramp - g)) / lim_ramp);
        if (t < lim) lim = t;
        if (p < 0) p = 0;
        if (lim < p - longint'(lim_step)) lim = p - longint'(lim_step);
        if (lim > p + longint'(lim_step)) lim = p + longint'(lim_step);
        if (lim < 0) lim = 0;
        if (lim > longint'(lim_max)) lim = longint'(lim_max);
        return lim[15:0];
    endfunction

    class speed_scoreboard;
        logic [15:0] pending[$];
        int errors;
        int checked;

        function void note_arc(logic [15:0] cmd);
            pending.push_back(cmd);
        endfunction

        function void check_command(logic [15:0] got);
            logic [15:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected speed_command: expected none actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                $display("%0t speed_command mismatch: expected %0d actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    speed_scoreboard sb;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_arc(predict_speed(curvature, clear_length, goal_distance, previous_speed));
        if (rst_n && done)
            sb.check_command(speed_command);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_TOP_SPEED:      lim_max = 64'(val[15:0]);
            REG_BASE_SPEED:     lim_min = 64'(val[15:0]);
            REG_LAT_ACCEL_MAX:  lim_lat = 64'(val[15:0]);
            REG_BRAKE_DECEL:    lim_brake = 64'(val[15:0]);
            REG_REACTION_DELAY: lim_delay = 64'(val[15:0]);
            REG_STOP_MARGIN:    lim_margin = 64'(val[19:0]);
            REG_RAMP_DISTANCE:  lim_ramp = 64'(val[19:0]);
            default:            lim_step = 64'(val[15:0]);
        endcase
    endtask

    task automatic send_arc(logic [23:0] k, logic [20:0] fl, logic [20:0] g, logic [16:0] p);
        while (!quiet && $urandom_range(0, 99) < 10)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        curvature <= k;
        clear_length <= fl;
        goal_distance <= g;
        previous_speed <= p;
        @(posedge clk);
        while (busy) @(posedge clk);
        n_items++;
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_arcs(int count);
        logic [23:0] k;
        logic [20:0] fl;
        logic [20:0] g;
        logic [16:0] p;
        for (int i = 0; i < count; i++)
        begin
            quiet = (i >= count / 3 && i < count / 2);
            k = 24'($urandom());
            if ($urandom_range(0, 3) == 0) k = k >>> $urandom_range(0, 23);
            if ($urandom_range(0, 15) == 0) k = 0;
            fl = 21'($urandom());
            if ($urandom_range(0, 2) != 0) fl = 21'($urandom_range(0, 20000));
            g = 21'($urandom());
            if ($urandom_range(0, 2) != 0) g = 21'($urandom_range(0, 32'(lim_ramp + 10)));
            p = 17'($urandom());
            if ($urandom_range(0, 2) != 0) p = 17'($urandom_range(0, 32'(lim_max + 100)));
            send_arc(k, fl, g, p);
        end
        quiet = 0;
    endtask

    task automatic load_setting(logic [15:0] mx, logic [15:0] mn, logic [15:0] lat,
                                logic [15:0] brk, logic [15:0] dly, logic [19:0] mrg,
                                logic [19:0] rmp, logic [15:0] stp);
        write_reg(REG_TOP_SPEED, 32'(mx));
        write_reg(REG_BASE_SPEED, 32'(mn));
        write_reg(REG_LAT_ACCEL_MAX, 32'(lat));
        write_reg(REG_BRAKE_DECEL, 32'(brk));
        write_reg(REG_REACTION_DELAY, 32'(dly));
        write_reg(REG_STOP_MARGIN, 32'(mrg));
        write_reg(REG_RAMP_DISTANCE, 32'(rmp));
        write_reg(REG_SPEED_STEP, 32'(stp));
        n_phases++;
    endtask

    initial
    begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        lim_max = 1000; lim_min = 100; lim_lat = 2000; lim_brake = 1000;
        lim_delay = 100; lim_margin = 200; lim_ramp = 1000; lim_step = 50;
        rst_n = 0; start = 0; curvature = 0; clear_length = 0; goal_distance = 0;
        previous_speed = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        quiet = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero curvature, short lengths, ramp ends
        send_arc(24'd0, 21'd100000, 21'd100000, 17'd1000);
        send_arc(24'h7FFFFF, 21'h0FFFFF, 21'h0FFFFF, 17'h0FFFF);
        send_arc(24'h800000, 21'h100000, 21'h100000, 17'h10000);
        send_arc(24'hFFFFFF, 21'd200, 21'd0, 17'd0);
        send_arc(24'd1, 21'd201, 21'd999, 17'd500);
        send_arc(24'd65536, 21'd0, 21'd1000, 17'h1FFFF);
        send_arc(24'hFF0000, 21'd5000, 21'd500, 17'd980);
        send_arc(24'd100, 21'h1FFFFF, 21'h1FFFFF, 17'd30);
        drain();
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                     20'hFFFFF, 16'hFFFF);
        send_arc(24'd0, 21'h0FFFFF, 21'h0FFFFF, 17'h0FFFF);
        send_arc(24'd1, 21'h0FFFFF, 21'd1, 17'd0);
        send_arc(24'h800000, 21'h0FFFFF, 21'h0FFFFE, 17'h10000);
        drain();
        // zero lat accel, zero decel, zero step, min above max, no ramp
        load_setting(16'd500, 16'd2000, 16'd0, 16'd0, 16'd0, 20'd0, 20'd0, 16'd0);
        send_arc(24'd5, 21'd1000, 21'd10, 17'd300);
        send_arc(24'd0, 21'd1000, 21'd10, 17'd900);
        send_arc(24'd0, 21'd1, 21'h100000, 17'h1FF00);
        drain();
        load_setting(16'd3000, 16'd4000, 16'd1, 16'd1, 16'd0, 20'd0, 20'd5000, 16'd1);
        send_arc(24'd1, 21'd1, 21'd2500, 17'd10);
        send_arc(24'd0, 21'd10, 21'd4999, 17'd2999);
        drain();

        load_setting(16'd1000, 16'd100, 16'd2000, 16'd1000, 16'd100, 20'd200, 20'd1000, 16'd50);
        random_arcs(200);
        drain();
        load_setting(16'd4000, 16'd0, 16'd8000, 16'd3000, 16'd250, 20'd50, 20'd8000, 16'd4000);
        random_arcs(200);
        drain();
        load_setting(16'hFFFF, 16'd30000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'd1,
                     16'hFFFF);
        random_arcs(150);
        drain();
        load_setting(16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 20'd0, 20'hFFFFF, 16'd1);
        random_arcs(150);
        drain();

        $display("covered %0d arcs over %0d register settings, %0d commands checked",
                 n_items, n_phases + 1, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
